>>> rtl/tridiagonal_matrix_row_product_core_defines.svh
// Assertion macros shared by the tridiagonal row product RTL.
`ifndef TRIDIAGONAL_MATRIX_ROW_PRODUCT_CORE_DEFINES_SVH
`define TRIDIAGONAL_MATRIX_ROW_PRODUCT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset
`define TMRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");

// Next-cycle implication, disabled in reset
`define TMRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");

`else

`define TMRP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TMRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/tmrp_pkg.sv
// Shared types and constants of the tridiagonal row product core.
`default_nettype none
package tmrp_pkg;

    localparam int DATA_W        = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int CFG_IDX_W     = 8;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DIAGONAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BAND     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_DIAGONAL  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BAND     = CFG_IDX_W'(3);

    localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRACTION_BITS;

    // One product element to compute: the three window taps and its flags
    typedef struct packed {
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] center;
        logic [DATA_W-1:0] right;
        logic              first;
        logic              last;
    } job_t;

    // Up to two jobs pushed per beat; job0 goes in first
    typedef struct packed {
        logic [1:0] num;
        job_t       job0;
        job_t       job1;
    } push_t;

    // Coefficient set seen by the arithmetic
    typedef struct packed {
        logic [DATA_W-1:0] first_diagonal;
        logic [DATA_W-1:0] lower_band;
        logic [DATA_W-1:0] main_diagonal;
        logic [DATA_W-1:0] upper_band;
    } coef_t;

endpackage
`default_nettype wire

>>> rtl/tridiagonal_matrix_row_product_core.sv
// Top level of the dense-times-tridiagonal row product core.
// A dense matrix streams in row-major order, one Q16.16 element per beat, and each
// beat is accepted whenever the four-entry job queue has room for two jobs; tlast on
// an input beat ends the row. Each element yields zero, one or two product beats (a
// held element is emitted when its right neighbour arrives, and the row's last
// element is flushed at tlast), so the sustained rate is one input beat per cycle while
// m_tready stays high, and products leave at up to one per cycle, the limit set by the
// single three-multiplier pipeline that serves all jobs. A job that leaves the queue
// passes through the product registers, the sum register and the shift-and-clamp
// output register, and a low m_tready holds every stage; the second job of a row end
// follows the first out of the queue.
// Coefficients are written through the cfg port, indexes 0 to 3, and must be
// written only while no product is outstanding; other indexes are ignored.
`default_nettype none
`include "tridiagonal_matrix_row_product_core_defines.svh"
module tridiagonal_matrix_row_product_core
    import tmrp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DATA_W-1:0]    s_tdata,   // [31:0] element
    input  wire logic                 s_tlast,   // row_end
    // Output stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [DATA_W-1:0]         m_tdata,   // [31:0] product
    output logic                      m_tlast,   // row_last
    output logic                      m_tuser,   // [0] saturated
    // Coefficient writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    coef_t coef_reg;
    push_t push;
    logic  room;
    logic  pop;
    logic  head_valid;
    job_t  head;
    logic  in_beat;

    assign s_tready  = room;
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.first_diagonal <= ONE_Q;
            coef_reg.lower_band     <= '0;
            coef_reg.main_diagonal  <= ONE_Q;
            coef_reg.upper_band     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FIRST_DIAGONAL: coef_reg.first_diagonal <= cfg_data;
                REG_LOWER_BAND:     coef_reg.lower_band     <= cfg_data;
                REG_MAIN_DIAGONAL:  coef_reg.main_diagonal  <= cfg_data;
                REG_UPPER_BAND:     coef_reg.upper_band     <= cfg_data;
                default:            ;
            endcase
        end
    end

    tmrp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_beat),
        .element (s_tdata),
        .row_end (s_tlast),
        .push    (push)
    );

    tmrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    tmrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .product    (m_tdata),
        .row_last   (m_tlast),
        .saturated  (m_tuser)
    );

    // Jobs are only created by an accepted beat
    `TMRP_ASSERT_IMPL(a_push_on_beat, clk, rst_n, push.num != 2'd0, in_beat)
    // A row end always produces the row's closing job
    `TMRP_ASSERT_IMPL(a_row_end_pushes, clk, rst_n, in_beat && s_tlast, push.num != 2'd0)
    // When two jobs go in, the second one closes the row
    `TMRP_ASSERT_IMPL(a_pair_closes_row, clk, rst_n, push.num == 2'd2, push.job1.last)
    // The back end never pops an empty queue
    `TMRP_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, head_valid)

endmodule
`default_nettype wire

>>> rtl/tmrp_queue.sv
// Four-entry job queue that takes up to two jobs and gives one per cycle while the back end does not stall.
`default_nettype none
module tmrp_queue
    import tmrp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       room,
    input  wire logic  pop,
    output logic       head_valid,
    output job_t       head
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_plus1;

    // Room for two jobs is always required, so the front never needs the pop
    assign room         = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign head_valid   = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);

    // Pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.num) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.job0;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.job1;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tmrp_front.sv
// Input side: keeps the row window and turns each element into zero to two jobs.
`default_nettype none
module tmrp_front
    import tmrp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [DATA_W-1:0] element,
    input  wire logic              row_end,
    output push_t                  push
);

    logic [DATA_W-1:0] left_reg, left_next;
    logic [DATA_W-1:0] center_reg, center_next;
    logic              pending_reg, pending_next;
    logic              first_reg, first_next;
    job_t              job_held;
    job_t              job_new;

    // Held element, completed by the new one as right neighbour
    always_comb
    begin
        job_held.left   = first_reg ? '0 : left_reg;
        job_held.center = center_reg;
        job_held.right  = element;
        job_held.first  = first_reg;
        job_held.last   = 1'b0;
    end

    // Incoming element flushed at row end with a zero right neighbour
    always_comb
    begin
        job_new.left   = pending_reg ? center_reg : '0;
        job_new.center = element;
        job_new.right  = '0;
        job_new.first  = !pending_reg;
        job_new.last   = 1'b1;
    end

    // Job selection and window update
    always_comb
    begin
        push.num     = 2'd0;
        push.job0    = job_held;
        push.job1    = job_new;
        left_next    = left_reg;
        center_next  = center_reg;
        pending_next = pending_reg;
        first_next   = first_reg;
        if (accept)
        begin
            if (pending_reg)
            begin
                push.num = row_end ? 2'd2 : 2'd1;
            end
            else if (row_end)
            begin
                push.num  = 2'd1;
                push.job0 = job_new;
            end
            if (row_end)
            begin
                left_next    = '0;
                center_next  = '0;
                pending_next = 1'b0;
                first_next   = 1'b1;
            end
            else
            begin
                left_next    = pending_reg ? center_reg : '0;
                center_next  = element;
                pending_next = 1'b1;
                first_next   = !pending_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            first_reg   <= 1'b1;
        end
        else
        begin
            pending_reg <= pending_next;
            first_reg   <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        center_reg <= center_next;
    end

endmodule
`default_nettype wire

>>> rtl/tmrp_back.sv
// Arithmetic side: three products, exact sum, then shift and clamp into the output register.
`default_nettype none
module tmrp_back
    import tmrp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire coef_t             coef,
    input  wire logic              head_valid,
    input  wire job_t              head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      product,
    output logic                   row_last,
    output logic                   saturated
);

    localparam logic signed [SUM_W-1:0] RES_MAX = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] RES_MIN = -RES_MAX - SUM_W'(1);

    // Stage 1: products
    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] p_left_reg, p_center_reg, p_right_reg;
    logic                     s1_last_reg;
    logic signed [PROD_W-1:0] p_left_next, p_center_next, p_right_next;
    logic signed [DATA_W-1:0] diag;

    // Stage 2: sum
    logic                     s2_valid_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic                     s2_last_reg;

    // Stage 3: output register
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        product_reg, product_next;
    logic                     row_last_reg;
    logic                     saturated_reg, saturated_next;
    logic signed [SUM_W-1:0]  shifted;

    logic s3_ready, s2_ready, s1_ready;

    // Stall chain from the output back to the queue
    assign s3_ready = !out_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign pop      = head_valid && s1_ready;

    // Multiplies
    always_comb
    begin
        diag          = head.first ? coef.first_diagonal : coef.main_diagonal;
        p_left_next   = PROD_W'($signed(coef.upper_band)) * PROD_W'($signed(head.left));
        p_center_next = PROD_W'(diag) * PROD_W'($signed(head.center));
        p_right_next  = PROD_W'($signed(coef.lower_band)) * PROD_W'($signed(head.right));
    end

    // Exact three-way sum
    assign sum_next = SUM_W'(p_left_reg) + SUM_W'(p_center_reg) + SUM_W'(p_right_reg);

    // Floor shift and clamp
    always_comb
    begin
        shifted        = sum_reg >>> FRACTION_BITS;
        saturated_next = 1'b0;
        product_next   = shifted[DATA_W-1:0];
        if (shifted > RES_MAX)
        begin
            product_next   = RES_MAX[DATA_W-1:0];
            saturated_next = 1'b1;
        end
        else if (shifted < RES_MIN)
        begin
            product_next   = RES_MIN[DATA_W-1:0];
            saturated_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= head_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p_left_reg   <= p_left_next;
            p_center_reg <= p_center_next;
            p_right_reg  <= p_right_next;
            s1_last_reg  <= head.last;
        end
        if (s1_valid_reg && s2_ready)
        begin
            sum_reg     <= sum_next;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_valid_reg && s3_ready)
        begin
            product_reg   <= product_next;
            row_last_reg  <= s2_last_reg;
            saturated_reg <= saturated_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign product   = product_reg;
    assign row_last  = row_last_reg;
    assign saturated = saturated_reg;

endmodule
`default_nettype wire
